FILE: rtl/json_string_escaper_utf8_unit_assert.svh
// Assertion macros for the escaper. Each expects clk and rst_n in scope.
`ifndef JSON_STRING_ESCAPER_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_UNIT_ASSERT_SVH

// Flag any cycle at which expr holds.
`define JSE_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// Require cons in the same cycle as ante.
`define JSE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/jse_pkg.sv
package jse_pkg;

    localparam int MAX_BYTES = 12;
    localparam int IDX_W     = 4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        string_last;
    } unit_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } result_t;

    // All bytes caused by one accepted code unit, byte 0 goes out first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [IDX_W-1:0]          count;
        logic                      last;
    } job_t;

endpackage

FILE: rtl/json_string_escaper_utf8_unit.sv
// JSON string escaper: takes UTF-16 code units, one per transaction, and sends out the
// bytes of the escaped UTF-8 text, one byte per transaction, with run_last on the final
// byte of each unit's output and string_end on the final byte of the string. The front
// classifies each unit and pairs surrogates; the back serializes bytes through an output
// register, so the output port moves one byte per cycle while jobs wait and byte_stall
// is low. A unit produces one byte for plain ASCII, 2 to 6 for escapes and multi-byte
// forms, up to 12 when an unpaired held surrogate is flushed ahead of an escaped unit.
// A held high surrogate produces no bytes until the next unit arrives. A QUEUE_DEPTH deep
// job queue between front and back absorbs bursts; the input stalls only while it is full.
`include "json_string_escaper_utf8_unit_assert.svh"

module json_string_escaper_utf8_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             unit_valid,
    output logic             unit_stall,
    input  jse_pkg::unit_t   unit_data,
    output logic             byte_valid,
    input  logic             byte_stall,
    output jse_pkg::result_t byte_data
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          head_valid;
    logic          last_accept;
    jse_pkg::job_t wr_job;
    jse_pkg::job_t head;

    jse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_data  (unit_data),
        .q_full     (q_full),
        .push       (push),
        .job        (wr_job)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (wr_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data)
    );

    assign last_accept = unit_valid && !unit_stall && unit_data.string_last;

    `JSE_ASSERT_NEVER(a_queue_no_overflow, push && q_full, "job pushed into a full queue")
    `JSE_ASSERT_IMPLY(a_last_unit_pushes, last_accept, push, "string end gave no bytes")
    `JSE_ASSERT_IMPLY(a_pop_needs_head, pop, head_valid && head.count != '0, "pop with no job")

endmodule

FILE: rtl/jse_front.sv
module jse_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           unit_valid,
    output logic           unit_stall,
    input  jse_pkg::unit_t unit_data,
    input  logic           q_full,
    output logic           push,
    output jse_pkg::job_t  job
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_TAB   = 8'h09;
    localparam logic [7:0] CTL_LF    = 8'h0a;
    localparam logic [7:0] CTL_FF    = 8'h0c;
    localparam logic [7:0] CTL_CR    = 8'h0d;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'ha) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
    endfunction

    logic             pending_valid_reg, pending_valid_next;
    logic [9:0]       pending_high_reg, pending_high_next;
    logic [15:0]      u;
    logic             last;
    logic             accept;
    logic             is_sur, is_high, is_low;
    logic [5:0][7:0]  unit_bytes;
    logic [2:0]       unit_cnt;
    logic [5:0][7:0]  flush_bytes;
    logic [20:0]      cp;

    assign u       = unit_data.code_unit;
    assign last    = unit_data.string_last;
    assign is_sur  = (u[15:11] == 5'b11011);
    assign is_high = is_sur && !u[10];
    assign is_low  = is_sur && u[10];

    assign unit_stall = q_full;
    assign accept     = unit_valid && !q_full;
    assign push       = accept && (job.count != '0);

    // Encode the unit as if nothing were held.
    always_comb
    begin
        unit_bytes = '0;
        unit_cnt   = '0;
        priority if (u[15:7] == '0)
        begin
            if (u[6:5] == 2'b00 || u[7:0] == CH_QUOTE || u[7:0] == CH_BSLASH)
            begin
                unit_bytes[0] = CH_BSLASH;
                unit_cnt      = 3'd2;
                unique case (u[7:0])
                    CH_QUOTE:  unit_bytes[1] = CH_QUOTE;
                    CH_BSLASH: unit_bytes[1] = CH_BSLASH;
                    CTL_BS:    unit_bytes[1] = CH_B;
                    CTL_FF:    unit_bytes[1] = CH_F;
                    CTL_LF:    unit_bytes[1] = CH_N;
                    CTL_CR:    unit_bytes[1] = CH_R;
                    CTL_TAB:   unit_bytes[1] = CH_T;
                    default:
                    begin
                        unit_bytes[1] = CH_U;
                        unit_bytes[2] = CH_ZERO;
                        unit_bytes[3] = CH_ZERO;
                        unit_bytes[4] = hex_char(u[7:4]);
                        unit_bytes[5] = hex_char(u[3:0]);
                        unit_cnt      = 3'd6;
                    end
                endcase
            end
            else
            begin
                unit_bytes[0] = u[7:0];
                unit_cnt      = 3'd1;
            end
        end
        else if (u[15:11] == '0)
        begin
            unit_bytes[0] = {3'b110, u[10:6]};
            unit_bytes[1] = {2'b10, u[5:0]};
            unit_cnt      = 3'd2;
        end
        else if (!is_sur)
        begin
            unit_bytes[0] = {4'b1110, u[15:12]};
            unit_bytes[1] = {2'b10, u[11:6]};
            unit_bytes[2] = {2'b10, u[5:0]};
            unit_cnt      = 3'd3;
        end
        else if (is_high && !last)
        begin
            unit_cnt = '0;
        end
        else
        begin
            unit_bytes[0] = CH_BSLASH;
            unit_bytes[1] = CH_U;
            unit_bytes[2] = hex_char(u[15:12]);
            unit_bytes[3] = hex_char(u[11:8]);
            unit_bytes[4] = hex_char(u[7:4]);
            unit_bytes[5] = hex_char(u[3:0]);
            unit_cnt      = 3'd6;
        end
    end

    assign flush_bytes[0] = CH_BSLASH;
    assign flush_bytes[1] = CH_U;
    assign flush_bytes[2] = hex_char(4'hd);
    assign flush_bytes[3] = hex_char({2'b10, pending_high_reg[9:8]});
    assign flush_bytes[4] = hex_char(pending_high_reg[7:4]);
    assign flush_bytes[5] = hex_char(pending_high_reg[3:0]);

    assign cp = 21'h10000 + {1'b0, pending_high_reg, u[9:0]};

    always_comb
    begin
        job.data  = '0;
        job.count = '0;
        job.last  = last;
        priority if (pending_valid_reg && is_low)
        begin
            job.data[0] = {5'b11110, cp[20:18]};
            job.data[1] = {2'b10, cp[17:12]};
            job.data[2] = {2'b10, cp[11:6]};
            job.data[3] = {2'b10, cp[5:0]};
            job.count   = jse_pkg::IDX_W'(4);
        end
        else if (pending_valid_reg)
        begin
            job.data[5:0]  = flush_bytes;
            job.data[11:6] = unit_bytes;
            job.count      = jse_pkg::IDX_W'(6) + jse_pkg::IDX_W'(unit_cnt);
        end
        else
        begin
            job.data[5:0] = unit_bytes;
            job.count     = jse_pkg::IDX_W'(unit_cnt);
        end
    end

    // Hold a high surrogate until the next accepted unit pairs or flushes it; one that ends a string is not held.
    always_comb
    begin
        pending_valid_next = pending_valid_reg;
        pending_high_next  = pending_high_reg;
        if (accept)
        begin
            pending_valid_next = is_high && !last;
            pending_high_next  = (is_high && !last) ? u[9:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_high_reg  <= '0;
        end
        else
        begin
            pending_valid_reg <= pending_valid_next;
            pending_high_reg  <= pending_high_next;
        end
    end

endmodule

FILE: rtl/jse_queue.sv
module jse_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jse_pkg::job_t wr_job,
    input  logic          pop,
    output jse_pkg::job_t head,
    output logic          head_valid,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

FILE: rtl/jse_back.sv
module jse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  jse_pkg::job_t    head,
    input  logic             head_valid,
    output logic             pop,
    output logic             byte_valid,
    input  logic             byte_stall,
    output jse_pkg::result_t byte_data
);

    logic [jse_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    jse_pkg::result_t          out_data_reg, out_data_next;
    logic                      load;
    logic                      last_byte;

    assign load      = head_valid && (!out_valid_reg || !byte_stall);
    assign last_byte = (idx_reg == head.count - 1'b1);
    assign pop       = load && last_byte;

    assign byte_valid = out_valid_reg;
    assign byte_data  = out_data_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && byte_stall;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.out_byte   = head.data[idx_reg];
            out_data_next.run_last   = last_byte;
            out_data_next.string_end = last_byte && head.last;
            idx_next                 = last_byte ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
